### design/exptok_pkg.sv
// ----------------------------------------------------------------------------
// exptok_pkg
// Shared types, codes and the character classifier of the expression
// tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package exptok_pkg;

	localparam int unsigned MAX_LEN_DEFAULT = 4096;

	localparam int unsigned START_W = 12;
	localparam int unsigned LEN_W   = 13;
	localparam int unsigned CODE_W  = 2;

	localparam logic [START_W-1:0] START_SAT = '1;

	// Characters with a meaning of their own.
	localparam logic [7:0] CHR_PLUS   = 8'h2B;
	localparam logic [7:0] CHR_MINUS  = 8'h2D;
	localparam logic [7:0] CHR_STAR   = 8'h2A;
	localparam logic [7:0] CHR_SLASH  = 8'h2F;
	localparam logic [7:0] CHR_EQ     = 8'h3D;
	localparam logic [7:0] CHR_LT     = 8'h3C;
	localparam logic [7:0] CHR_GT     = 8'h3E;
	localparam logic [7:0] CHR_PCT    = 8'h25;
	localparam logic [7:0] CHR_COMMA  = 8'h2C;
	localparam logic [7:0] CHR_LPAR   = 8'h28;
	localparam logic [7:0] CHR_RPAR   = 8'h29;
	localparam logic [7:0] CHR_UNDER  = 8'h5F;
	localparam logic [7:0] CHR_DOT    = 8'h2E;
	localparam logic [7:0] CHR_SPACE  = 8'h20;
	localparam logic [7:0] CHR_TAB    = 8'h09;

	typedef enum logic [2:0] {
		CC_BLANK,
		CC_ALPHA,
		CC_DIGIT,
		CC_OPER,
		CC_STRAY
	} char_class_t;

	typedef enum logic [CODE_W-1:0] {
		KIND_TOKEN = 2'd0,
		KIND_ERROR = 2'd1,
		KIND_END   = 2'd2
	} kind_t;

	typedef enum logic [CODE_W-1:0] {
		TT_IDENT  = 2'd0,
		TT_NUMBER = 2'd1,
		TT_OPER   = 2'd2
	} tok_type_t;

	typedef enum logic [CODE_W-1:0] {
		ERR_STRAY = 2'd0,
		ERR_ALPHA = 2'd1,
		ERR_LONG  = 2'd2
	} err_code_t;

	typedef struct packed {
		kind_t                kind;
		logic [CODE_W-1:0]    token_type;
		logic [START_W-1:0]   start_pos;
		logic [LEN_W-1:0]     length;
		logic [CODE_W-1:0]    error_code;
		logic                 last;
	} result_t;

	function automatic char_class_t class_of(input logic [7:0] c);
		char_class_t k;
		if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || c == CHR_UNDER) begin
			k = CC_ALPHA;
		end else if ((c >= 8'h30 && c <= 8'h39) || c == CHR_DOT) begin
			k = CC_DIGIT;
		end else if (c == CHR_SPACE || c == CHR_TAB) begin
			k = CC_BLANK;
		end else if (c == CHR_PLUS || c == CHR_MINUS || c == CHR_STAR || c == CHR_SLASH ||
			     c == CHR_EQ || c == CHR_LT || c == CHR_GT || c == CHR_PCT ||
			     c == CHR_COMMA || c == CHR_LPAR || c == CHR_RPAR) begin
			k = CC_OPER;
		end else begin
			k = CC_STRAY;
		end
		return k;
	endfunction

endpackage

`default_nettype wire

### design/expression_tokenizer_core.sv
// ----------------------------------------------------------------------------
// expression_tokenizer_core
// Splits an expression, one character per beat, into identifier, number
// and operator tokens, and reports stray characters and overlong text.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Payload                                    Frame mark
//  s_axis   in   tdata[7:0] character                       tlast: final character
//  m_axis   out  tdata: type, start, length, error code     tlast: final result
//                tuser: result kind
//
// Each character sits in the input register while the classifier and position
// counter produce up to two results, which go into a four-entry result queue.
// The input side advances whenever the queue has room for two results after
// this cycle's read, so one character per cycle is sustained as long as
// results are drained at one per cycle. Only the final character of an
// expression can leave two results, when it closes a token and starts a
// one-character token; these take two output beats. Reset clears the position
// counter, the open token and the queue; no clearing pass is needed.
`default_nettype none

module expression_tokenizer_core #(
	parameter int unsigned MAX_LEN = exptok_pkg::MAX_LEN_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] ch
	input  wire logic        s_axis_tlast,

	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,   // [1:0] token_type, [13:2] start_pos,
	                                         // [26:14] length, [28:27] error_code
	output logic [1:0]       m_axis_tuser,   // [1:0] kind
	output logic             m_axis_tlast
);
	import exptok_pkg::*;

	localparam int unsigned POS_W = $clog2(MAX_LEN + 1);
	localparam int unsigned PAD_W = POS_W + LEN_W;
	localparam int unsigned DEPTH = 4;
	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	// Input register.
	logic             valid_s1;
	logic [7:0]       ch_s1;
	logic             eot_s1;

	// Tokenizer state.
	logic [POS_W-1:0] pos_q, pos_d;
	logic [POS_W-1:0] start_q, start_d;
	tok_type_t        type_q, type_d;
	logic             cmp_q, cmp_d;      // open operator is < or > and may take '='
	logic             open_q, open_d;
	logic             abort_q, abort_d;

	// Result queue.
	result_t          queue_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	logic             fire;
	logic             pop;
	logic [CNT_W-1:0] cnt_after_pop;
	logic [1:0]       n_res;
	result_t          res0, res1, tok_res, one_res;
	char_class_t      cls;
	logic             ext;
	logic             done;
	logic [PAD_W-1:0] pos_pad, start_pad, len_base, len_plus;
	logic [START_W-1:0] err_pos;

	assign pop           = m_axis_tvalid && m_axis_tready;
	assign cnt_after_pop = cnt_q - CNT_W'(pop);
	assign fire          = valid_s1 && (cnt_after_pop <= CNT_W'(DEPTH - 2));
	assign s_axis_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			ch_s1  <= s_axis_tdata;
			eot_s1 <= s_axis_tlast;
		end
	end

	assign cls       = class_of(ch_s1);
	assign pos_pad   = PAD_W'(pos_q);
	assign start_pad = PAD_W'(start_q);
	assign len_base  = pos_pad - start_pad;
	assign len_plus  = len_base + PAD_W'(1);
	assign err_pos   = (pos_pad > PAD_W'(START_SAT)) ? START_SAT : pos_pad[START_W-1:0];

	// Result for the token that is open when this character arrives.
	always_comb begin
		tok_res            = '0;
		tok_res.kind       = KIND_TOKEN;
		tok_res.token_type = type_q;
		tok_res.start_pos  = start_pad[START_W-1:0];
		tok_res.length     = len_base[LEN_W-1:0];
	end

	always_comb begin
		n_res   = 2'd0;
		res0    = '0;
		res1    = '0;
		one_res = '0;
		ext     = 1'b0;
		done    = 1'b0;
		pos_d   = pos_q;
		start_d = start_q;
		type_d  = type_q;
		cmp_d   = cmp_q;
		open_d  = open_q;
		abort_d = abort_q;

		if (fire) begin
			if (abort_q) begin
				done = 1'b1;
			end else if (pos_q >= POS_W'(MAX_LEN) || cls == CC_STRAY ||
				     (open_q && type_q == TT_NUMBER && cls == CC_ALPHA)) begin
				res0.kind      = KIND_ERROR;
				res0.start_pos = err_pos;
				res0.last      = 1'b1;
				if (pos_q >= POS_W'(MAX_LEN)) begin
					res0.error_code = ERR_LONG;
				end else if (cls == CC_STRAY) begin
					res0.error_code = ERR_STRAY;
				end else begin
					res0.error_code = ERR_ALPHA;
				end
				n_res   = 2'd1;
				open_d  = 1'b0;
				abort_d = 1'b1;
				done    = 1'b1;
			end else if (open_q) begin
				unique case (type_q)
					TT_IDENT:  ext = (cls == CC_ALPHA) || (cls == CC_DIGIT);
					TT_NUMBER: ext = (cls == CC_DIGIT);
					TT_OPER:   ext = cmp_q && (ch_s1 == CHR_EQ);
					default:   ext = 1'b0;
				endcase
				if (ext) begin
					// The character joins the open token.
					res0        = tok_res;
					res0.length = len_plus[LEN_W-1:0];
					res0.last   = 1'b1;
					n_res       = eot_s1 ? 2'd1 : 2'd0;
					cmp_d       = 1'b0;
					pos_d       = pos_q + POS_W'(1);
					done        = 1'b1;
				end else begin
					res0      = tok_res;
					res0.last = eot_s1 && (cls == CC_BLANK);
					n_res     = 2'd1;
					open_d    = 1'b0;
				end
			end

			if (!done) begin
				if (cls != CC_BLANK) begin
					open_d  = 1'b1;
					start_d = pos_q;
					cmp_d   = (ch_s1 == CHR_LT) || (ch_s1 == CHR_GT);
					if (cls == CC_ALPHA) begin
						type_d = TT_IDENT;
					end else if (cls == CC_DIGIT) begin
						type_d = TT_NUMBER;
					end else begin
						type_d = TT_OPER;
					end
					one_res            = '0;
					one_res.kind       = KIND_TOKEN;
					one_res.token_type = type_d;
					one_res.start_pos  = pos_pad[START_W-1:0];
					one_res.length     = LEN_W'(1);
					one_res.last       = 1'b1;
				end else begin
					one_res      = '0;
					one_res.kind = KIND_END;
					one_res.last = 1'b1;
				end
				if (eot_s1 && (cls != CC_BLANK || n_res == 2'd0)) begin
					if (n_res == 2'd0) begin
						res0 = one_res;
					end else begin
						res1 = one_res;
					end
					n_res = n_res + 2'd1;
				end
				pos_d = pos_q + POS_W'(1);
			end

			// The final character always starts the next expression afresh.
			if (eot_s1) begin
				pos_d   = '0;
				start_d = '0;
				cmp_d   = 1'b0;
				open_d  = 1'b0;
				abort_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			start_q  <= '0;
			type_q   <= TT_IDENT;
			cmp_q    <= 1'b0;
			open_q   <= 1'b0;
			abort_q  <= 1'b0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			pos_q    <= pos_d;
			start_q  <= start_d;
			type_q   <= type_d;
			cmp_q    <= cmp_d;
			open_q   <= open_d;
			abort_q  <= abort_d;
			wr_ptr_q <= wr_ptr_q + PTR_W'(n_res);
			rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
			cnt_q    <= cnt_after_pop + CNT_W'(n_res);
		end
	end

	always_ff @(posedge clk) begin
		if (n_res != 2'd0) begin
			queue_q[wr_ptr_q] <= res0;
		end
		if (n_res == 2'd2) begin
			queue_q[wr_ptr_q + PTR_W'(1)] <= res1;
		end
	end

	assign m_axis_tvalid = (cnt_q != '0);
	assign m_axis_tdata  = {3'b000,
				queue_q[rd_ptr_q].error_code,
				queue_q[rd_ptr_q].length,
				queue_q[rd_ptr_q].start_pos,
				queue_q[rd_ptr_q].token_type};
	assign m_axis_tuser  = queue_q[rd_ptr_q].kind;
	assign m_axis_tlast  = queue_q[rd_ptr_q].last;

	// The queue never overflows.
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CNT_W'(DEPTH))
		else $error("result queue overflow");

	// A swallowed character never produces a result.
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && abort_q) |-> (n_res == 2'd0))
		else $error("result while swallowing");

	// An error always closes the expression's output.
	assert property (@(posedge clk) disable iff (!arst_n)
		(n_res != 2'd0 && res0.kind == KIND_ERROR) |-> (res0.last && n_res == 2'd1))
		else $error("error result without last");

	// The final character leaves the tokenizer at position zero with no open token.
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && eot_s1) |=> (pos_q == '0 && !open_q && !abort_q))
		else $error("state not cleared at end of expression");

	// Two results only come from a character that ends the expression.
	assert property (@(posedge clk) disable iff (!arst_n)
		(n_res == 2'd2) |-> (fire && eot_s1 && res1.last && !res0.last))
		else $error("unexpected second result");

endmodule

`default_nettype wire

### bench/expression_tokenizer_core_test.sv
// ----------------------------------------------------------------------------
// expression_tokenizer_core_test
// Streams expressions into the tokenizer one character per beat and checks
// every result beat against a tokenizer tracked in the bench. A short directed
// pass covers every operator, the two-character comparisons and the stray and
// letter-after-number errors. Random expressions built from identifier, number,
// operator and blank pieces with some byte noise follow. Both streams idle at
// random.
// ----------------------------------------------------------------------------

module expression_tokenizer_core_test;

	timeunit 1ns;
	timeprecision 1ps;

	import exptok_pkg::*;

	localparam int unsigned MAX_CHARS    = MAX_LEN_DEFAULT;
	localparam int unsigned RANDOM_CHARS = 800;

	localparam logic [7:0] OPERATORS [11] = '{CHR_PLUS, CHR_MINUS, CHR_STAR, CHR_SLASH,
		CHR_EQ, CHR_LT, CHR_GT, CHR_PCT, CHR_COMMA, CHR_LPAR, CHR_RPAR};

	// Tracks the tokenizer state and holds the result beats still to come.
	class token_tracker;
		result_t     expected_tokens[$];
		int unsigned mismatches;
		int unsigned char_pos;
		int unsigned tok_start;
		tok_type_t   tok_kind;
		bit          tok_open;
		bit          swallowing;
		bit          pair_ok;

		function new();
			mismatches = 0;
			restart();
		endfunction

		function void restart();
			char_pos   = 0;
			tok_start  = 0;
			tok_kind   = TT_IDENT;
			tok_open   = 1'b0;
			swallowing = 1'b0;
			pair_ok    = 1'b0;
		endfunction

		function char_class_t classify(logic [7:0] c);
			if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == CHR_UNDER)
				return CC_ALPHA;
			if ((c >= "0" && c <= "9") || c == CHR_DOT)
				return CC_DIGIT;
			if (c == CHR_SPACE || c == CHR_TAB)
				return CC_BLANK;
			foreach (OPERATORS[i])
				if (c == OPERATORS[i])
					return CC_OPER;
			return CC_STRAY;
		endfunction

		function void push(kind_t kind, logic [1:0] tt, int unsigned start,
				int unsigned len, logic [1:0] code, bit last);
			result_t r;
			r.kind       = kind;
			r.token_type = tt;
			r.start_pos  = start[START_W-1:0];
			r.length     = len[LEN_W-1:0];
			r.error_code = code;
			r.last       = last;
			expected_tokens.insert(expected_tokens.size(), r);
		endfunction

		// An error closes the expression's output; what is left of it is dropped.
		function void fail_expr(err_code_t code, bit eot);
			push(KIND_ERROR, 2'd0, (char_pos > 4095) ? 4095 : char_pos, 0, code, 1'b1);
			if (eot) begin
				restart();
			end else begin
				tok_open   = 1'b0;
				swallowing = 1'b1;
			end
		endfunction

		function void take_char(logic [7:0] c, bit eot);
			char_class_t k;
			bit          grows;
			bit          closed;
			if (swallowing) begin
				if (eot)
					restart();
				return;
			end
			if (char_pos >= MAX_CHARS) begin
				fail_expr(ERR_LONG, eot);
				return;
			end
			k = classify(c);
			if (k == CC_STRAY) begin
				fail_expr(ERR_STRAY, eot);
				return;
			end
			closed = 1'b0;
			if (tok_open) begin
				if (tok_kind == TT_NUMBER && k == CC_ALPHA) begin
					fail_expr(ERR_ALPHA, eot);
					return;
				end
				case (tok_kind)
					TT_IDENT:  grows = (k == CC_ALPHA || k == CC_DIGIT);
					TT_NUMBER: grows = (k == CC_DIGIT);
					default:   grows = pair_ok && c == CHR_EQ && char_pos - tok_start == 1;
				endcase
				if (grows) begin
					if (eot) begin
						push(KIND_TOKEN, tok_kind, tok_start, char_pos - tok_start + 1,
							2'd0, 1'b1);
						restart();
					end else begin
						char_pos++;
					end
					return;
				end
				push(KIND_TOKEN, tok_kind, tok_start, char_pos - tok_start, 2'd0,
					eot && k == CC_BLANK);
				tok_open = 1'b0;
				closed   = 1'b1;
			end
			if (k != CC_BLANK) begin
				tok_open  = 1'b1;
				tok_start = char_pos;
				tok_kind  = (k == CC_ALPHA) ? TT_IDENT : (k == CC_DIGIT) ? TT_NUMBER : TT_OPER;
				pair_ok   = (c == CHR_LT || c == CHR_GT);
				if (eot)
					push(KIND_TOKEN, tok_kind, char_pos, 1, 2'd0, 1'b1);
			end else if (eot && !closed) begin
				push(KIND_END, 2'd0, 0, 0, 2'd0, 1'b1);
			end
			if (eot)
				restart();
			else
				char_pos++;
		endfunction

		function void compare(string field, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s: expected %0d, got %0d", field, want, got);
				mismatches++;
			end
		endfunction

		function void match_result(result_t got);
			result_t want;
			if (expected_tokens.size() == 0) begin
				$error("result beat with none expected: kind %0d start %0d length %0d",
					got.kind, got.start_pos, got.length);
				mismatches++;
				return;
			end
			want = expected_tokens.pop_front();
			compare("kind", want.kind, got.kind);
			compare("token_type", want.token_type, got.token_type);
			compare("start_pos", want.start_pos, got.start_pos);
			compare("length", want.length, got.length);
			compare("error_code", want.error_code, got.error_code);
			compare("last", want.last, got.last);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'd0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;

	token_tracker tracker = new();
	bit           send_calm = 1'b0;
	bit           recv_calm = 1'b0;
	logic [7:0]   expr_text[$];

	expression_tokenizer_core #(
		.MAX_LEN(MAX_CHARS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Each side now and then switches between idling freely and running flat out.
	function automatic int unsigned draw_wait(ref bit calm);
		if ($urandom_range(0, 39) == 0)
			calm = !calm;
		return calm ? 0 : $urandom_range(0, 17);
	endfunction

	function automatic void add_byte(input logic [7:0] c);
		expr_text.insert(expr_text.size(), c);
	endfunction

	task automatic send_char(input logic [7:0] c, input bit eot);
		int unsigned gap;
		gap = draw_wait(send_calm);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= c;
		s_axis_tlast  <= eot;
		do @(posedge clk); while (!s_axis_tready);
		tracker.take_char(c, eot);
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], i == s.len() - 1);
	endtask

	function automatic logic [7:0] pick_char(char_class_t cls);
		int unsigned r;
		case (cls)
			CC_ALPHA: begin
				r = $urandom_range(0, 52);
				return (r < 26) ? 8'("A" + r) : (r < 52) ? 8'("a" + r - 26) : CHR_UNDER;
			end
			CC_DIGIT: begin
				r = $urandom_range(0, 10);
				return (r < 10) ? 8'("0" + r) : CHR_DOT;
			end
			CC_BLANK: return $urandom_range(0, 1) ? CHR_SPACE : CHR_TAB;
			CC_OPER:  return OPERATORS[$urandom_range(0, 10)];
			default:  return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Mostly well-formed pieces, blank-separated half the time, with rare noise bytes.
	task automatic make_expr();
		int unsigned pieces;
		int unsigned run;
		char_class_t cls;
		expr_text.delete();
		pieces = $urandom_range(1, 8);
		repeat (pieces) begin
			case ($urandom_range(0, 24))
				0:             cls = CC_STRAY;
				1, 2, 3, 4:    cls = CC_BLANK;
				5, 6, 7, 8, 9: cls = CC_OPER;
				10, 11, 12, 13, 14, 15, 16: cls = CC_DIGIT;
				default:       cls = CC_ALPHA;
			endcase
			run = $urandom_range(1, 6);
			if (cls == CC_OPER && $urandom_range(0, 2) == 0) begin
				add_byte($urandom_range(0, 1) ? CHR_LT : CHR_GT);
				add_byte(CHR_EQ);
			end else if (cls == CC_STRAY || cls == CC_OPER) begin
				add_byte(pick_char(cls));
			end else begin
				add_byte(pick_char(cls));
				for (int unsigned j = 1; j < run; j++)
					add_byte(pick_char((cls == CC_ALPHA && $urandom_range(0, 3) == 0) ?
						CC_DIGIT : cls));
			end
			if ($urandom_range(0, 1))
				add_byte(pick_char(CC_BLANK));
		end
	endtask

	initial begin
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			int unsigned stall;
			result_t     got;
			stall = draw_wait(recv_calm);
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			got.kind       = kind_t'(m_axis_tuser);
			got.token_type = m_axis_tdata[1:0];
			got.start_pos  = m_axis_tdata[13:2];
			got.length     = m_axis_tdata[26:14];
			got.error_code = m_axis_tdata[28:27];
			got.last       = m_axis_tlast;
			tracker.match_result(got);
			@(negedge clk);
		end
	end

	initial begin
		#10_000_000;
		$display("expression_tokenizer_core_test failed");
		$finish;
	end

	initial begin
		int unsigned sent;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_text("A_z9<=0.5");
		send_text("a+b-c*d/e=f<g>h%i,(j)");
		send_text("<==>=\t");
		send_text(" \t");
		send_text("x  $y 1");
		send_text("12.5ab+1");
		send_char(8'h00, 1'b1);
		send_char(8'hFF, 1'b0);
		send_char("q", 1'b1);
		send_text("9");

		sent = 0;
		while (sent < RANDOM_CHARS) begin
			make_expr();
			foreach (expr_text[i])
				send_char(expr_text[i], i == expr_text.size() - 1);
			sent += expr_text.size();
		end
		s_axis_tvalid <= 1'b0;

		while (tracker.expected_tokens.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.expected_tokens.size() == 0)
			$display("expression_tokenizer_core_test passed");
		else
			$display("expression_tokenizer_core_test failed");
		$finish;
	end

endmodule
